/* hdl/mau_pkg.sv */
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Opcodes shared by the core and its datapath.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam logic [2:0] OP_REDUCE = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;
    localparam logic [2:0] OP_POW    = 3'd5;
    localparam logic [2:0] OP_NEG    = 3'd6;
    localparam logic [2:0] OP_EQ     = 3'd7;

endpackage

/* hdl/modular_arithmetic_unit_core.sv */
// ----------------------------------------------------------------------------
// Modular arithmetic unit core
// One residue result per command, modulo the configured modulus.
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  command   opcode operand_a operand_b exponent       start & !busy
//            raw_value
//  result    result is_equal                           done, one cycle
//  config    modulus_we modulus_wdata                  modulus_we
//
// Reduction of a, b and raw_value uses a restoring divider, one quotient bit
// a cycle. Multiply runs in the shared bit-serial multiplier; power and
// divide run square and multiply over the exponent bits, up to two
// multiplies a bit. busy is high from the accepted command through done.
// The receiver cannot stall; reset returns the modulus to 1000000007.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_core
    import mau_pkg::*;
#(
    parameter int RESIDUE_BITS  = 62,
    parameter int EXPONENT_BITS = 63
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               opcode,
    input  logic [RESIDUE_BITS-1:0]  operand_a,
    input  logic [RESIDUE_BITS-1:0]  operand_b,
    input  logic [EXPONENT_BITS-1:0] exponent,
    input  logic signed [63:0]       raw_value,
    input  logic                     modulus_we,
    input  logic [RESIDUE_BITS-1:0]  modulus_wdata,
    output logic                     done,
    output logic [RESIDUE_BITS-1:0]  result,
    output logic                     is_equal
);

    localparam int W  = RESIDUE_BITS;
    localparam int EB = (EXPONENT_BITS > W) ? EXPONENT_BITS : W;
    localparam int DC = $clog2(65);
    localparam int EC = $clog2(EB + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_REDA  = 4'd1;
    localparam logic [3:0] S_REDB  = 4'd2;
    localparam logic [3:0] S_REDR  = 4'd3;
    localparam logic [3:0] S_DISP  = 4'd4;
    localparam logic [3:0] S_PBIT  = 4'd5;
    localparam logic [3:0] S_PMUL  = 4'd6;
    localparam logic [3:0] S_PSQ   = 4'd7;
    localparam logic [3:0] S_FMUL  = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [W-1:0]  mod_reg, mod_next;
    logic [3:0]    st_reg, st_next;
    logic [2:0]    op_reg, op_next;
    logic [W-1:0]  a_reg, a_next, b_reg, b_next;
    logic [W-1:0]  acc_reg, acc_next, x_reg, x_next;
    logic [EB-1:0] e_reg, e_next;
    logic [EC-1:0] ecnt_reg, ecnt_next;
    logic [63:0]   dq_reg, dq_next;
    logic [W:0]    rem_reg, rem_next;
    logic [DC-1:0] dcnt_reg, dcnt_next;
    logic          neg_reg, neg_next;
    logic [3:0]    ret_reg, ret_next;
    logic [W-1:0]  res_reg, res_next;
    logic          eq_reg, eq_next;
    logic          done_reg, done_next;

    logic          mgo;
    logic [W-1:0]  ma, mb, mp;
    logic          mdone;
    logic [W+1:0]  rsh, rdif;
    logic [W:0]    s1, s2;
    logic [W-1:0]  one_m;

    mau_mulmod #(.W(W)) u_mul (
        .clk(clk), .rst_n(rst_n), .go(mgo), .a(ma), .b(mb), .m(mod_reg),
        .done(mdone), .p(mp)
    );

    always_comb
    begin
        rsh   = {rem_reg, dq_reg[63]};
        rdif  = rsh - {2'b00, mod_reg};
        one_m = (mod_reg == W'(1)) ? '0 : W'(1);
        s1 = '0;
        s2 = '0;
        mod_next  = modulus_we ? modulus_wdata : mod_reg;
        st_next   = st_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        e_next    = e_reg;
        ecnt_next = ecnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dcnt_next = dcnt_reg;
        neg_next  = neg_reg;
        ret_next  = ret_reg;
        res_next  = res_reg;
        eq_next   = eq_reg;
        done_next = 1'b0;
        mgo = 1'b0;
        ma  = acc_reg;
        mb  = x_reg;
        unique case (st_reg)
            S_IDLE:
            begin
                if (start && !done_reg)
                begin
                    op_next  = opcode;
                    b_next   = operand_b;
                    e_next   = EB'(exponent);
                    neg_next = raw_value[63];
                    res_next = '0;
                    eq_next  = 1'b0;
                    dq_next  = 64'(operand_a);
                    rem_next = '0;
                    dcnt_next = DC'(64);
                    if (mod_reg < W'(2))
                        st_next = S_OUT;
                    else if (opcode == OP_REDUCE)
                    begin
                        dq_next = raw_value[63] ? 64'(-raw_value) : raw_value;
                        st_next = S_REDR;
                    end
                    else
                        st_next = S_REDA;
                end
            end
            S_REDA, S_REDB, S_REDR:
            begin
                // Restoring division step: one quotient bit a cycle.
                rem_next  = rdif[W+1] ? rsh[W:0] : rdif[W:0];
                dq_next   = {dq_reg[62:0], 1'b0};
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DC'(1))
                begin
                    dcnt_next = DC'(64);
                    if (st_reg == S_REDA)
                    begin
                        a_next  = rem_next[W-1:0];
                        dq_next = 64'(b_reg);
                        st_next = S_REDB;
                    end
                    else if (st_reg == S_REDB)
                    begin
                        b_next  = rem_next[W-1:0];
                        st_next = S_DISP;
                    end
                    else
                    begin
                        if (neg_reg && rem_next != '0)
                            res_next = mod_reg - rem_next[W-1:0];
                        else
                            res_next = rem_next[W-1:0];
                        st_next = S_OUT;
                    end
                    rem_next = '0;
                end
            end
            S_DISP:
            begin
                st_next = S_OUT;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        s1 = {1'b0, a_reg} + {1'b0, b_reg};
                        s2 = s1 - {1'b0, mod_reg};
                        res_next = s2[W] ? s1[W-1:0] : s2[W-1:0];
                    end
                    OP_SUB:
                        res_next = (a_reg < b_reg) ? a_reg + mod_reg - b_reg
                                                   : a_reg - b_reg;
                    OP_NEG:
                        res_next = (a_reg == '0) ? '0 : mod_reg - a_reg;
                    OP_EQ:
                        eq_next = (a_reg == b_reg);
                    OP_MUL:
                    begin
                        mgo = 1'b1; ma = a_reg; mb = b_reg;
                        ret_next = S_OUT;
                        st_next  = S_WAIT;
                    end
                    OP_POW:
                    begin
                        acc_next  = one_m;
                        x_next    = a_reg;
                        ecnt_next = EC'(EB);
                        st_next   = S_PBIT;
                    end
                    OP_DIV:
                    begin
                        acc_next  = one_m;
                        x_next    = b_reg;
                        e_next    = EB'(mod_reg - W'(2));
                        ecnt_next = EC'(EB);
                        st_next   = S_PBIT;
                    end
                    default:
                        st_next = S_OUT;
                endcase
            end
            S_PBIT:
            begin
                if (ecnt_reg == '0 || e_reg == '0)
                begin
                    if (op_reg == OP_DIV)
                    begin
                        mgo = 1'b1; ma = a_reg; mb = acc_reg;
                        ret_next = S_FMUL;
                        st_next  = S_WAIT;
                    end
                    else
                    begin
                        res_next = acc_reg;
                        st_next  = S_OUT;
                    end
                end
                else if (e_reg[0])
                begin
                    mgo = 1'b1; ma = acc_reg; mb = x_reg;
                    ret_next = S_PMUL;
                    st_next  = S_WAIT;
                end
                else
                begin
                    mgo = 1'b1; ma = x_reg; mb = x_reg;
                    ret_next = S_PSQ;
                    st_next  = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (mdone)
                begin
                    priority if (ret_reg == S_PMUL)
                    begin
                        acc_next = mp;
                        mgo = 1'b1; ma = x_reg; mb = x_reg;
                        ret_next = S_PSQ;
                    end
                    else if (ret_reg == S_PSQ)
                    begin
                        x_next    = mp;
                        e_next    = e_reg >> 1;
                        ecnt_next = ecnt_reg - 1'b1;
                        st_next   = S_PBIT;
                    end
                    else
                    begin
                        res_next = mp;
                        st_next  = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                done_next = 1'b1;
                st_next   = S_IDLE;
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= W'(64'd1000000007);
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            mod_reg  <= mod_next;
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        e_reg    <= e_next;
        ecnt_reg <= ecnt_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        neg_reg  <= neg_next;
        ret_reg  <= ret_next;
        res_reg  <= res_next;
        eq_reg   <= eq_next;
    end

    assign busy     = (st_reg != S_IDLE) || done_reg;
    assign done     = done_reg;
    assign result   = res_reg;
    assign is_equal = eq_reg;

endmodule

/* hdl/mau_mulmod.sv */
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Double-and-add over the bits of b, most significant first, one bit a cycle.
// ----------------------------------------------------------------------------
module mau_mulmod
    import mau_pkg::*;
#(
    parameter int W = 62
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] p
);

    localparam int CW = $clog2(W + 1);

    logic          run_reg, run_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  r_reg, r_next;
    logic          done_reg, done_next;
    logic [W:0]    dbl, dsub, sum, ssub;
    logic [W-1:0]  r1;

    always_comb
    begin
        dbl  = {r_reg, 1'b0};
        dsub = dbl - {1'b0, m};
        r1   = dsub[W] ? dbl[W-1:0] : dsub[W-1:0];
        sum  = {1'b0, r1} + (b_reg[W-1] ? {1'b0, a_reg} : '0);
        ssub = sum - {1'b0, m};
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        done_next = 1'b0;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = CW'(W);
            a_next   = a;
            b_next   = b;
            r_next   = '0;
        end
        else if (run_reg)
        begin
            r_next   = ssub[W] ? sum[W-1:0] : ssub[W-1:0];
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign p    = r_reg;

endmodule
